@@ sv/assert_macros.svh @@
// Assertion helpers: all checks are clocked on the rising edge and
// disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/bmmd_pkg.sv @@
`timescale 1ns / 1ps
package bmmd_pkg;

  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int KB_W    = 7;
  localparam int BANK_W  = 5;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // last entry of the zero-reset region (everything below 0xC000: RAM, the 0x8xxx ROM window and the I/O area)
  localparam logic [ADDR_W-1:0] CLR_LAST = 16'hBFFF;

  localparam logic [DATA_W-1:0] UNMAPPED_BYTE = 8'hFF;
  localparam logic [DATA_W-1:0] ZERO_BYTE     = 8'h00;

  localparam logic [KB_W-1:0] RESET_KB = 7'd5;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_PRELOAD = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef logic [BANK_W-1:0] bank_t;

  // Threshold table: installed KB to bank enables.
  function automatic bank_t size_to_banks(input logic [KB_W-1:0] kb);
    bank_t b;
    priority if (kb < 7'd8)  b = 5'h00;
    else if (kb < 7'd13) b = 5'h01;
    else if (kb < 7'd16) b = 5'h02;
    else if (kb < 7'd21) b = 5'h03;
    else if (kb < 7'd24) b = 5'h06;
    else if (kb < 7'd29) b = 5'h07;
    else if (kb < 7'd32) b = 5'h0E;
    else if (kb < 7'd37) b = 5'h0F;
    else if (kb < 7'd40) b = 5'h1E;
    else                 b = 5'h1F;
    return b;
  endfunction

endpackage

@@ sv/banked_memory_map_decoder_unit.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Signals
// in        request    in_valid/in_ready, in_opcode, in_address, in_write_data
// out       result     out_valid/out_ready, out_read_data, out_mapped
// cfg       write      cfg_we, cfg_ram_kb
//
// One request per cycle sustained while the output is not stalled; a result passes
// through the decode and RAM access stage, then the output register.
// All storage is one 64K x 8 single-port RAM indexed by bus address.
// After reset a clearing pass zeroes 0x0000-0xBFFF with in_ready low;
// cfg writes are taken during the pass.
// A stalled output holds the pipeline; in_ready drops only when it is full or during the clearing pass.
module banked_memory_map_decoder_unit
  import bmmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [DATA_W-1:0] in_write_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_read_data,
  output logic              out_mapped,
  input  logic              cfg_we,
  input  logic [KB_W-1:0]   cfg_ram_kb
);

`include "assert_macros.svh"

  bank_t             bank_r;
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic              p1_valid_r, p1_mem_r, p1_mapped_r;
  logic [DATA_W-1:0] p1_byte_r;
  logic              out_valid_r, out_mapped_r;
  logic [DATA_W-1:0] out_read_data_r;

  logic              accept, p1_adv;
  logic              ram_hit, char_win, io_win, rom_win;
  logic              do_read, do_write, hit;
  logic [DATA_W-1:0] byte_nxt;
  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  op_t               op;

  assign op     = op_t'(in_opcode);
  assign p1_adv = !out_valid_r || out_ready;
  assign in_ready = !clr_busy_r && (!p1_valid_r || p1_adv);
  assign accept = in_valid && in_ready;

  // address windows
  always_comb begin
    char_win = in_address[15:12] == 4'h8;
    io_win   = in_address[15:12] == 4'h9;
    rom_win  = in_address[15:14] == 2'b11;
    priority if (in_address[15:10] == 6'd0)    ram_hit = 1'b1;
    else if (in_address[15:12] == 4'h0)        ram_hit = bank_r[0];
    else if (in_address[15:12] == 4'h1)        ram_hit = 1'b1;
    else if (in_address[15:13] == 3'b001)      ram_hit = bank_r[1];
    else if (in_address[15:13] == 3'b010)      ram_hit = bank_r[2];
    else if (in_address[15:13] == 3'b011)      ram_hit = bank_r[3];
    else if (in_address[15:13] == 3'b101)      ram_hit = bank_r[4];
    else                                       ram_hit = 1'b0;
  end

  always_comb begin
    do_read  = 1'b0;
    do_write = 1'b0;
    byte_nxt = ZERO_BYTE;
    unique case (op)
      OP_READ: begin
        do_read = ram_hit || char_win || io_win || rom_win;
        if (!do_read) byte_nxt = UNMAPPED_BYTE;
      end
      OP_WRITE:   do_write = ram_hit || io_win;
      OP_PRELOAD: do_write = char_win || rom_win;
      OP_NONE:    ;
      default:    ;
    endcase
    hit = do_read || do_write;
  end

  // clearing pass owns the port until done
  always_comb begin
    if (clr_busy_r) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_r;
      ram_wdata = ZERO_BYTE;
    end else begin
      ram_en    = accept && hit;
      ram_we    = do_write;
      ram_addr  = in_address;
      ram_wdata = in_write_data;
    end
  end

  bmmd_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MEM_DEPTH)
  ) u_mem (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r     <= size_to_banks(RESET_KB);
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      if (cfg_we) bank_r <= size_to_banks(cfg_ram_kb);
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == CLR_LAST) clr_busy_r <= 1'b0;
      end
    end
  end

  // decode/access stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (accept) begin
      p1_valid_r <= 1'b1;
    end else if (p1_adv) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_mem_r    <= do_read;
      p1_mapped_r <= hit;
      p1_byte_r   <= byte_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p1_adv) begin
      out_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv && p1_valid_r) begin
      out_read_data_r <= p1_mem_r ? ram_rdata : p1_byte_r;
      out_mapped_r    <= p1_mapped_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_mapped    = out_mapped_r;

  `ASSERT_NXT(a_accept_fills_p1, clk, rst_n, accept, p1_valid_r)
  `ASSERT_NXT(a_p1_holds, clk, rst_n, p1_valid_r && !p1_adv, p1_valid_r && $stable(p1_byte_r))
  `ASSERT_IMP(a_clear_ends, clk, rst_n, $fell(clr_busy_r), $past(clr_cnt_r) == CLR_LAST)
  `ASSERT_IMP(a_unmapped_byte, clk, rst_n, out_valid_r && !out_mapped_r,
              out_read_data_r == UNMAPPED_BYTE || out_read_data_r == ZERO_BYTE)

endmodule

@@ sv/bmmd_ram.sv @@
`timescale 1ns / 1ps
module bmmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read data holds when the port is idle or writing
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sim/bmmd_access_checker.sv @@
`timescale 1ns / 1ps
module bmmd_access_checker
  import bmmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [DATA_W-1:0] out_read_data,
  input  logic              out_mapped,
  input  logic              cfg_we,
  input  logic [KB_W-1:0]   cfg_ram_kb,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              mapped;
  } access_result_t;

  // One flat image of the bus space: RAM, I/O and the ROMs at their own addresses.
  logic [DATA_W-1:0] bus_image [0:MEM_DEPTH-1];
  bank_t             bank_en;
  access_result_t    expected_q [$];
  int                fail_count = 0;

  function automatic bank_t kb_to_bank_en(input logic [KB_W-1:0] kb);
    if (kb < 8)  return 5'h00;
    if (kb < 13) return 5'h01;
    if (kb < 16) return 5'h02;
    if (kb < 21) return 5'h03;
    if (kb < 24) return 5'h06;
    if (kb < 29) return 5'h07;
    if (kb < 32) return 5'h0E;
    if (kb < 37) return 5'h0F;
    if (kb < 40) return 5'h1E;
    return 5'h1F;
  endfunction

  function automatic logic ram_here(input logic [ADDR_W-1:0] a);
    if (a < 16'h0400) return 1'b1;
    if (a < 16'h1000) return bank_en[0];
    if (a < 16'h2000) return 1'b1;
    if (a < 16'h4000) return bank_en[1];
    if (a < 16'h6000) return bank_en[2];
    if (a < 16'h8000) return bank_en[3];
    if (a >= 16'hA000 && a < 16'hC000) return bank_en[4];
    return 1'b0;
  endfunction

  function automatic access_result_t access_memory(input op_t op,
                                                   input logic [ADDR_W-1:0] a,
                                                   input logic [DATA_W-1:0] d);
    access_result_t r;
    logic in_ram, in_io, in_rom;
    in_ram = ram_here(a);
    in_io  = (a[15:12] == 4'h9);
    in_rom = (a[15:12] == 4'h8) || (a[15:14] == 2'b11);
    r.read_data = ZERO_BYTE;
    r.mapped    = 1'b0;
    case (op)
      OP_READ: begin
        if (in_ram || in_io || in_rom) begin
          r.read_data = bus_image[a];
          r.mapped    = 1'b1;
        end else begin
          r.read_data = UNMAPPED_BYTE;
        end
      end
      OP_WRITE: begin
        if (in_ram || in_io) begin
          bus_image[a] = d;
          r.mapped     = 1'b1;
        end
      end
      OP_PRELOAD: begin
        if (in_rom) begin
          bus_image[a] = d;
          r.mapped     = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < MEM_DEPTH; i++) bus_image[i] = ZERO_BYTE;
      bank_en = kb_to_bank_en(RESET_KB);
      expected_q.delete();
    end else begin
      // compare before taking new requests; a result never shares an edge with its request
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: read_data %02h, mapped %0b", out_read_data, out_mapped);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_read_data !== want.read_data) begin
            $error("read_data: expected %02h, got %02h", want.read_data, out_read_data);
            fail_count++;
          end
          if (out_mapped !== want.mapped) begin
            $error("mapped: expected %0b, got %0b", want.mapped, out_mapped);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(access_memory(op_t'(in_opcode), in_address, in_write_data));
      if (cfg_we) bank_en = kb_to_bank_en(cfg_ram_kb);
    end
    outstanding <= expected_q.size();
    mismatches  <= fail_count;
  end

endmodule

@@ sim/banked_memory_map_decoder_unit_tb.sv @@
`timescale 1ns / 1ps
module banked_memory_map_decoder_unit_tb;
  import bmmd_pkg::*;

  localparam int HALF_PERIOD = 2;
  // nothing is taken during the clearing pass after reset
  localparam int IDLE_LIMIT  = 200000;
  localparam int PHASE_REQS  = 93;
  localparam int RECENT_MAX  = 32;

  localparam logic [KB_W-1:0] KB_STEPS [21] = '{
    7'd0, 7'd7, 7'd8, 7'd12, 7'd13, 7'd15, 7'd16, 7'd20, 7'd21, 7'd23, 7'd24,
    7'd28, 7'd29, 7'd31, 7'd32, 7'd36, 7'd37, 7'd39, 7'd40, 7'd64, 7'd5
  };

  localparam logic [ADDR_W-1:0] REGION_EDGES [22] = '{
    16'h0000, 16'h03FF, 16'h0400, 16'h0FFF, 16'h1000, 16'h1FFF, 16'h2000, 16'h3FFF,
    16'h4000, 16'h5FFF, 16'h6000, 16'h7FFF, 16'h8000, 16'h8FFF, 16'h9000, 16'h9FFF,
    16'hA000, 16'hBFFF, 16'hC000, 16'hDFFF, 16'hE000, 16'hFFFF
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_opcode;
  logic [ADDR_W-1:0] in_address;
  logic [DATA_W-1:0] in_write_data;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] out_read_data;
  logic              out_mapped;
  logic              cfg_we;
  logic [KB_W-1:0]   cfg_ram_kb;

  int mismatches;
  int outstanding;
  int gap_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  bit                rom_loaded [0:MEM_DEPTH-1];
  logic [ADDR_W-1:0] rom_addrs [$];
  logic [ADDR_W-1:0] written_addrs [$];

  always #HALF_PERIOD clk = ~clk;

  banked_memory_map_decoder_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_read_data(out_read_data),
    .out_mapped   (out_mapped),
    .cfg_we       (cfg_we),
    .cfg_ram_kb   (cfg_ram_kb)
  );

  bmmd_access_checker access_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_read_data(out_read_data),
    .out_mapped   (out_mapped),
    .cfg_we       (cfg_we),
    .cfg_ram_kb   (cfg_ram_kb),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic is_rom_addr(input logic [ADDR_W-1:0] a);
    return (a[15:12] == 4'h8) || (a[15:14] == 2'b11);
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 45) return OP_READ;
    if (r < 80) return OP_WRITE;
    if (r < 95) return OP_PRELOAD;
    return OP_NONE;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address(input op_t op);
    logic [ADDR_W-1:0] a;
    case ($urandom_range(9))
      0, 1, 2: a = ADDR_W'($urandom_range(16'hFFFF));
      3, 4, 5: begin
        if (written_addrs.size() != 0)
          a = written_addrs[$urandom_range(written_addrs.size() - 1)];
        else
          a = ADDR_W'($urandom_range(16'hFFFF));
      end
      6, 7:    a = REGION_EDGES[$urandom_range(21)];
      8:       a = ADDR_W'($urandom_range(16'h9FFF, 16'h9000));
      default: a = rom_addrs[$urandom_range(rom_addrs.size() - 1)];
    endcase
    if (op == OP_PRELOAD && $urandom_range(3) != 0)
      a = ADDR_W'($urandom_range(1) ? $urandom_range(16'h8FFF, 16'h8000)
                                    : $urandom_range(16'hFFFF, 16'hC000));
    // never read a ROM byte that was not loaded
    if (op == OP_READ && is_rom_addr(a) && !rom_loaded[a])
      a = rom_addrs[$urandom_range(rom_addrs.size() - 1)];
    return a;
  endfunction

  task automatic send_req(input op_t op, input logic [ADDR_W-1:0] a,
                          input logic [DATA_W-1:0] d);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_address    <= a;
    in_write_data <= d;
    if (op == OP_PRELOAD && is_rom_addr(a) && !rom_loaded[a]) begin
      rom_loaded[a] = 1'b1;
      rom_addrs.push_back(a);
    end
    if (op == OP_WRITE) begin
      written_addrs.push_back(a);
      if (written_addrs.size() > RECENT_MAX) void'(written_addrs.pop_front());
    end
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and hold until every request has its result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_ram_size(input logic [KB_W-1:0] kb);
    drain();
    repeat (4) @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_ram_kb <= kb;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    op_t op;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_READ;
    in_address    = '0;
    in_write_data = '0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_ram_kb    = RESET_KB;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // all banks present: ROM window edges, RAM, I/O, cartridge RAM, ignored accesses
    set_ram_size(7'd64);
    send_req(OP_READ,    16'h0000, 8'h00);
    send_req(OP_PRELOAD, 16'h8000, 8'h00);
    send_req(OP_PRELOAD, 16'h8FFF, 8'hFF);
    send_req(OP_PRELOAD, 16'hC000, 8'h5A);
    send_req(OP_PRELOAD, 16'hDFFF, 8'hA5);
    send_req(OP_PRELOAD, 16'hE000, 8'h01);
    send_req(OP_PRELOAD, 16'hFFFF, 8'h80);
    send_req(OP_READ,    16'h8000, 8'h00);
    send_req(OP_READ,    16'h8FFF, 8'h00);
    send_req(OP_READ,    16'hDFFF, 8'h00);
    send_req(OP_READ,    16'hE000, 8'h00);
    send_req(OP_READ,    16'hFFFF, 8'h00);
    send_req(OP_WRITE,   16'hC000, 8'h77);
    send_req(OP_READ,    16'hC000, 8'h00);
    send_req(OP_WRITE,   16'h0000, 8'hFF);
    send_req(OP_READ,    16'h0000, 8'h00);
    send_req(OP_WRITE,   16'h9000, 8'hAA);
    send_req(OP_READ,    16'h9000, 8'h00);
    send_req(OP_WRITE,   16'hBFFF, 8'h3C);
    send_req(OP_READ,    16'hBFFF, 8'h00);
    send_req(OP_PRELOAD, 16'h1000, 8'h11);
    send_req(OP_READ,    16'h1000, 8'h00);
    send_req(OP_NONE,    16'h1234, 8'hEE);

    // no banks: absent reads and writes
    set_ram_size(7'd0);
    send_req(OP_WRITE,   16'h0400, 8'h55);
    send_req(OP_READ,    16'h0400, 8'h00);
    send_req(OP_READ,    16'hBFFF, 8'h00);

    for (int p = 0; p < $size(KB_STEPS); p++) begin
      set_ram_size(KB_STEPS[p]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 64; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 64; end
        default: begin gap_pct = 26; stall_pct <= 26; end
      endcase
      for (int i = 0; i < PHASE_REQS; i++) begin
        if (p % 5 == 2 && i == PHASE_REQS / 2) drain();
        op = pick_op();
        send_req(op, pick_address(op), DATA_W'($urandom_range(255)));
      end
    end

    drain();
    stall_pct <= 0;
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/bmmd_pkg.sv
sv/bmmd_ram.sv
sv/banked_memory_map_decoder_unit.sv
sim/bmmd_access_checker.sv
sim/banked_memory_map_decoder_unit_tb.sv
